### design/assert_macros.svh
// Assertion macros shared by the slot allocator modules.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define SSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// expression must never be true outside reset
`define SSA_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define SSA_ASSERT(label, clk, rst, prop)
`define SSA_NEVER(label, clk, rst, expr)
`endif
`endif

### design/ssa_pkg.sv
// Package of the swap slot allocator: field widths, codes, defaults,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package ssa_pkg;

   // parameter defaults
   localparam int MAX_SLOTS_DEF        = 1024;
   localparam int SECTORS_PER_PAGE_DEF = 8;
   localparam int SECTOR_BYTES_DEF     = 512;

   // transaction field widths
   localparam int OPCODE_W   = 1;
   localparam int SLOT_IDX_W = 10;
   localparam int ADDR_W     = 32;
   localparam int SECT_W     = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 11;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   // bitmap row geometry
   localparam int ROW_BITS = 32;
   localparam int BIT_W    = 5;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_STORE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // controller -> datapath
   typedef struct packed {
      logic                take_req;  // latch accepted request
      logic                ptr_inc;   // step row pointer
      logic                clr_wr;    // clear row at pointer
      logic                rd_en;     // read row at pointer
      logic                alloc_wr;  // mark found slot used
      logic                free_wr;   // mark requested slot free
      logic                emit;      // load next sector command into output
      logic                emit_err;  // load error result into output
      logic [STATUS_W-1:0] err_code;
   } ssa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_load;
      logic range_err;
      logic alloc_ok;
      logic scan_end;
      logic slot_busy;
      logic out_free;
      logic page_last;
      logic clear_last;
   } ssa_sts_type;

endpackage

### design/ssa_ifs.sv
// Valid/ready channel interfaces of the swap slot allocator.
// Depends on ssa_pkg for the field widths.
`timescale 1ns / 1ps

interface ssa_req_if;
   logic                              valid;
   logic                              ready;
   logic [ssa_pkg::OPCODE_W-1:0]      opcode;
   logic [ssa_pkg::SLOT_IDX_W-1:0]    slot_index;
   logic [ssa_pkg::ADDR_W-1:0]        frame_address;
   modport source (output valid, opcode, slot_index, frame_address, input ready);
   modport sink   (input valid, opcode, slot_index, frame_address, output ready);
endinterface

interface ssa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ssa_pkg::SECT_W-1:0]        sector_address;
   logic [ssa_pkg::ADDR_W-1:0]        memory_address;
   logic                              to_disk;
   logic [ssa_pkg::SLOT_IDX_W-1:0]    chosen_slot;
   logic [ssa_pkg::STATUS_W-1:0]      status;
   logic                              last;
   modport source (output valid, sector_address, memory_address, to_disk, chosen_slot,
                   status, last, input ready);
   modport sink   (input valid, sector_address, memory_address, to_disk, chosen_slot,
                   status, last, output ready);
endinterface

interface ssa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ssa_pkg::CSR_W-1:0]         slot_count;
   modport source (output valid, slot_count, input ready);
   modport sink   (input valid, slot_count, output ready);
endinterface

### design/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ssa_ctrl.sv
// Sequencer of the swap slot allocator: clearing pass, bitmap scan, result issue.
// Depends on ssa_pkg and assert_macros.svh; drives the datapath by command struct.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output ssa_pkg::ssa_cmd_type cmd,
   input  ssa_pkg::ssa_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_ERR   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [ssa_pkg::STATUS_W-1:0]   err_ff, err_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      cmd      = '0;
      cmd.err_code = err_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (sts.op_load && sts.range_err) begin
               err_in   = ssa_pkg::STS_RANGE;
               state_in = S_ERR;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.op_load) begin
               if (sts.alloc_ok) begin
                  cmd.alloc_wr = 1'b1;
                  state_in     = S_EMIT;
               end else if (sts.scan_end) begin
                  err_in   = ssa_pkg::STS_FULL;
                  state_in = S_ERR;
               end else begin
                  cmd.ptr_inc = 1'b1;
                  state_in    = S_READ;
               end
            end else if (sts.slot_busy) begin
               cmd.free_wr = 1'b1;
               state_in    = S_EMIT;
            end else begin
               err_in   = ssa_pkg::STS_FREE;
               state_in = S_ERR;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.page_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         err_ff   <= ssa_pkg::STS_OK;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   // a row is only checked right after its read
   `SSA_ASSERT(a_check_follows_read, clock, reset, state_ff == S_CHECK |-> $past(state_ff) == S_READ)
   // results are only loaded into a free output stage
   `SSA_ASSERT(a_emit_into_free, clock, reset, (cmd.emit || cmd.emit_err) |-> sts.out_free)
   // at most one kind of bitmap write per cycle
   `SSA_NEVER(a_one_write, clock, reset, (cmd.clr_wr && (cmd.alloc_wr || cmd.free_wr)) || (cmd.alloc_wr && cmd.free_wr))
   // no new request while the bitmap is being cleared
   `SSA_NEVER(a_no_take_in_clear, clock, reset, cmd.take_req && cmd.clr_wr)

endmodule

### design/ssa_dp.sv
// Datapath of the swap slot allocator: request latch, row pointer, first-fit search,
// sector/address counters and output stage. Depends on ssa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssa_dp #(
   parameter int MAX_SLOTS        = ssa_pkg::MAX_SLOTS_DEF,
   parameter int SECTORS_PER_PAGE = ssa_pkg::SECTORS_PER_PAGE_DEF,
   parameter int SECTOR_BYTES     = ssa_pkg::SECTOR_BYTES_DEF,
   localparam int ROWS  = (MAX_SLOTS + ssa_pkg::ROW_BITS - 1) / ssa_pkg::ROW_BITS,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   // request payload
   input  logic [ssa_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [ssa_pkg::SLOT_IDX_W-1:0]     req_slot_index,
   input  logic [ssa_pkg::ADDR_W-1:0]         req_frame_address,
   // configuration write
   input  logic                               csr_valid,
   input  logic [ssa_pkg::CSR_W-1:0]          csr_slot_count,
   // result channel
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [ssa_pkg::SECT_W-1:0]         rsp_sector_address,
   output logic [ssa_pkg::ADDR_W-1:0]         rsp_memory_address,
   output logic                               rsp_to_disk,
   output logic [ssa_pkg::SLOT_IDX_W-1:0]     rsp_chosen_slot,
   output logic [ssa_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_last,
   // controller
   input  ssa_pkg::ssa_cmd_type               cmd,
   output ssa_pkg::ssa_sts_type               sts,
   // bitmap RAM
   output logic                               ram_wr_en,
   output logic                               ram_rd_en,
   output logic [ROW_W-1:0]                   ram_addr,
   output logic [ssa_pkg::ROW_BITS-1:0]       ram_wr_data,
   input  logic [ssa_pkg::ROW_BITS-1:0]       ram_rd_data
);

   localparam int CMP_W = ssa_pkg::max_int(ssa_pkg::max_int($clog2(MAX_SLOTS + 1),
                          ssa_pkg::CSR_W), ROW_W + ssa_pkg::BIT_W) + 1;
   localparam int PG_W  = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
   localparam logic [PG_W-1:0]  PG_LAST  = PG_W'(SECTORS_PER_PAGE - 1);
   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_SLOTS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

   // control registers
   logic [ssa_pkg::CSR_W-1:0]      csr_ff;
   logic [ROW_W-1:0]               ptr_ff, ptr_in;
   logic [ROW_W-1:0]               hint_ff, hint_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ssa_pkg::OPCODE_W-1:0]   op_ff;
   logic [ssa_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic [ssa_pkg::ADDR_W-1:0]     mem_ff;
   logic [ssa_pkg::SECT_W-1:0]     sect_ff;
   logic [ssa_pkg::SLOT_IDX_W-1:0] slot_ff;
   logic [PG_W-1:0]                cnt_ff;

   logic [ssa_pkg::SECT_W-1:0]     out_sect_ff;
   logic [ssa_pkg::ADDR_W-1:0]     out_mem_ff;
   logic                           out_disk_ff;
   logic [ssa_pkg::SLOT_IDX_W-1:0] out_slot_ff;
   logic [ssa_pkg::STATUS_W-1:0]   out_status_ff;
   logic                           out_last_ff;

   // search and compare
   logic [CMP_W-1:0]               csr_ext, live_n;
   logic [CMP_W-1:0]               idx_ext, slot_found, next_row_base;
   logic [ROW_W-1:0]               req_row, idx_row;
   logic [ssa_pkg::BIT_W-1:0]      find_bit;
   logic                           find_any;
   logic [ssa_pkg::BIT_W-1:0]      idx_bit;
   logic                           alloc_ok, range_err, slot_busy, out_free;
   logic [ssa_pkg::ROW_BITS-1:0]   find_mask, idx_mask;

   // effective slot count saturates at the bitmap size
   assign csr_ext = CMP_W'(csr_ff);
   assign live_n  = (csr_ext > MAX_CMP) ? MAX_CMP : csr_ext;

   assign req_row = ROW_W'(CMP_W'(req_slot_index) >> ssa_pkg::BIT_W);
   assign idx_ext = CMP_W'(idx_ff);
   assign idx_row = ROW_W'(idx_ext >> ssa_pkg::BIT_W);
   assign idx_bit = idx_ff[ssa_pkg::BIT_W-1:0];

   // lowest clear bit of the row just read
   always_comb begin
      find_any = 1'b0;
      find_bit = '0;
      for (int b = ssa_pkg::ROW_BITS - 1; b >= 0; b--) begin
         if (!ram_rd_data[b]) begin
            find_any = 1'b1;
            find_bit = ssa_pkg::BIT_W'(b);
         end
      end
   end

   assign slot_found    = (CMP_W'(ptr_ff) << ssa_pkg::BIT_W) | CMP_W'(find_bit);
   assign next_row_base = (CMP_W'(ptr_ff) + CMP_W'(1)) << ssa_pkg::BIT_W;
   assign alloc_ok      = find_any && (slot_found < live_n);
   assign range_err     = idx_ext >= live_n;
   assign slot_busy     = ram_rd_data[idx_bit];
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign find_mask     = ssa_pkg::ROW_BITS'(1) << find_bit;
   assign idx_mask      = ssa_pkg::ROW_BITS'(1) << idx_bit;

   // status to controller
   always_comb begin
      sts.op_load    = (op_ff == ssa_pkg::OP_LOAD);
      sts.range_err  = range_err;
      sts.alloc_ok   = alloc_ok;
      sts.scan_end   = next_row_base >= live_n;
      sts.slot_busy  = slot_busy;
      sts.out_free   = out_free;
      sts.page_last  = (cnt_ff == PG_LAST);
      sts.clear_last = (ptr_ff == ROW_LAST);
   end

   // bitmap RAM access, always at the row pointer
   assign ram_addr  = ptr_ff;
   assign ram_rd_en = cmd.rd_en;
   assign ram_wr_en = cmd.clr_wr || cmd.alloc_wr || cmd.free_wr;
   always_comb begin
      if (cmd.alloc_wr) begin
         ram_wr_data = ram_rd_data | find_mask;
      end else if (cmd.free_wr) begin
         ram_wr_data = ram_rd_data & ~idx_mask;
      end else begin
         ram_wr_data = '0;
      end
   end

   // row pointer and first-fit hint: rows below the hint are all used
   always_comb begin
      ptr_in  = ptr_ff;
      hint_in = hint_ff;
      if (cmd.take_req) begin
         ptr_in = (req_opcode == ssa_pkg::OP_LOAD) ? req_row : hint_ff;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + ROW_W'(1);
      end
      if (cmd.alloc_wr) begin
         hint_in = ptr_ff;
      end else if (cmd.free_wr && (idx_row < hint_ff)) begin
         hint_in = idx_row;
      end
   end

   // output stage valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit || cmd.emit_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= ssa_pkg::CSR_RESET;
         ptr_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            csr_ff <= csr_slot_count;
         end
         ptr_ff       <= ptr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request latch and per-sector counters
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff  <= req_opcode;
         idx_ff <= req_slot_index;
         mem_ff <= req_frame_address;
      end else if (cmd.emit) begin
         mem_ff <= mem_ff + ssa_pkg::ADDR_W'(SECTOR_BYTES);
      end
      if (cmd.alloc_wr) begin
         slot_ff <= ssa_pkg::SLOT_IDX_W'(slot_found);
         sect_ff <= ssa_pkg::SECT_W'(32'(slot_found) * 32'(SECTORS_PER_PAGE));
         cnt_ff  <= '0;
      end else if (cmd.free_wr) begin
         slot_ff <= idx_ff;
         sect_ff <= ssa_pkg::SECT_W'(32'(idx_ff) * 32'(SECTORS_PER_PAGE));
         cnt_ff  <= '0;
      end else if (cmd.emit) begin
         sect_ff <= sect_ff + ssa_pkg::SECT_W'(1);
         cnt_ff  <= cnt_ff + PG_W'(1);
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_sect_ff   <= sect_ff;
         out_mem_ff    <= mem_ff;
         out_disk_ff   <= (op_ff == ssa_pkg::OP_STORE);
         out_slot_ff   <= slot_ff;
         out_status_ff <= ssa_pkg::STS_OK;
         out_last_ff   <= (cnt_ff == PG_LAST);
      end else if (cmd.emit_err) begin
         out_sect_ff   <= '0;
         out_mem_ff    <= '0;
         out_disk_ff   <= (op_ff == ssa_pkg::OP_STORE);
         out_slot_ff   <= (op_ff == ssa_pkg::OP_LOAD) ? idx_ff : '0;
         out_status_ff <= cmd.err_code;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sector_address = out_sect_ff;
   assign rsp_memory_address = out_mem_ff;
   assign rsp_to_disk        = out_disk_ff;
   assign rsp_chosen_slot    = out_slot_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last           = out_last_ff;

   // a slot is only taken when it is free and below the count
   `SSA_ASSERT(a_alloc_legal, clock, reset, cmd.alloc_wr |-> alloc_ok)
   // a slot is only freed when in range and in use
   `SSA_ASSERT(a_free_legal, clock, reset, cmd.free_wr |-> (slot_busy && !range_err))
   // a loaded result is presented on the next cycle
   `SSA_ASSERT(a_emit_shows, clock, reset, (cmd.emit || cmd.emit_err) |=> rsp_valid_ff)

endmodule

### design/swap_slot_allocator.sv
// Swap slot allocator: used-slot bitmap in RAM, first-fit store, checked load.
// Channels: req_chan (request), rsp_chan (sector commands), csr_chan (slot count write).
// A store takes the lowest free slot below slot_count and returns one write command
// per sector of the page; a load checks the slot is in use, returns one read command
// per sector and frees it. Failures (swap full, slot free, index out of range) give one
// result with last set and change nothing.
// The bitmap is held as 32-slot rows in one RAM with one port used per cycle.
// A load tests its index, reads the row of its slot, checks it and then issues the
// SECTORS_PER_PAGE results. A store reads rows in turn from the first-fit pointer (the
// lowest row that may hold a free slot) until one holds a free slot below the count, then
// issues the SECTORS_PER_PAGE results. One request is handled at a time; the next
// is accepted while the final result still waits in the output register.
// Reset: slot_count returns to 1024 and a clearing pass over all ceil(MAX_SLOTS/32) rows
// (32 by default) zeroes the bitmap; requests are held off during it, csr writes are not.
// A stalled rsp_chan holds the current result and pauses the sector sequence.
// Depends on ssa_pkg, ssa_ifs, ssa_ram, ssa_ctrl and ssa_dp.
`timescale 1ns / 1ps
module swap_slot_allocator #(
   parameter int MAX_SLOTS        = ssa_pkg::MAX_SLOTS_DEF,
   parameter int SECTORS_PER_PAGE = ssa_pkg::SECTORS_PER_PAGE_DEF,
   parameter int SECTOR_BYTES     = ssa_pkg::SECTOR_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ssa_req_if.sink   req_chan,
   ssa_rsp_if.source rsp_chan,
   ssa_csr_if.sink   csr_chan
);

   localparam int ROWS  = (MAX_SLOTS + ssa_pkg::ROW_BITS - 1) / ssa_pkg::ROW_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   ssa_pkg::ssa_cmd_type          cmd;
   ssa_pkg::ssa_sts_type          sts;
   logic                          ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0]              ram_addr;
   logic [ssa_pkg::ROW_BITS-1:0]  ram_wr_data, ram_rd_data;

   // configuration writes are always taken
   assign csr_chan.ready = 1'b1;

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ssa_dp #(
      .MAX_SLOTS        (MAX_SLOTS),
      .SECTORS_PER_PAGE (SECTORS_PER_PAGE),
      .SECTOR_BYTES     (SECTOR_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_chan.opcode),
      .req_slot_index     (req_chan.slot_index),
      .req_frame_address  (req_chan.frame_address),
      .csr_valid          (csr_chan.valid),
      .csr_slot_count     (csr_chan.slot_count),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_sector_address (rsp_chan.sector_address),
      .rsp_memory_address (rsp_chan.memory_address),
      .rsp_to_disk        (rsp_chan.to_disk),
      .rsp_chosen_slot    (rsp_chan.chosen_slot),
      .rsp_status         (rsp_chan.status),
      .rsp_last           (rsp_chan.last),
      .cmd                (cmd),
      .sts                (sts),
      .ram_wr_en          (ram_wr_en),
      .ram_rd_en          (ram_rd_en),
      .ram_addr           (ram_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_data        (ram_rd_data)
   );

   // used-slot bitmap, one row of 32 slots per word
   ssa_ram #(
      .WIDTH (ssa_pkg::ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

endmodule
